[hw/rtl/nems_pkg.sv]
// nems_pkg: shared types and constants for the next-event min selector.
// Used by every module under hw/rtl; depends on nothing.
package nems_pkg;

  localparam logic [63:0] TIME_INF = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [6:0]  PROGRESS_PARTS = 7'd100;
  localparam logic [6:0]  COUNT_MAX = 7'd127;
  // floor(2^64 / 25), reciprocal for the progress-step divide
  localparam logic [63:0] RECIP_25 = 64'h0A3D_70A3_D70A_3D70;

  // opcodes
  localparam logic [2:0] OP_WR_STATE = 3'd0;
  localparam logic [2:0] OP_WR_EVENT = 3'd1;
  localparam logic [2:0] OP_WR_INPUT = 3'd2;
  localparam logic [2:0] OP_WR_FLAG  = 3'd3;
  localparam logic [2:0] OP_INIT     = 3'd4;
  localparam logic [2:0] OP_UPDATE   = 3'd5;

  // winner kinds, also used as table selects
  localparam logic [1:0] KIND_STATE = 2'd0;
  localparam logic [1:0] KIND_EVENT = 2'd1;
  localparam logic [1:0] KIND_INPUT = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_NUM_STATES = 3'd0;
  localparam logic [2:0] CFG_NUM_EVENTS = 3'd1;
  localparam logic [2:0] CFG_NUM_INPUTS = 3'd2;
  localparam logic [2:0] CFG_START_TIME = 3'd3;
  localparam logic [2:0] CFG_FINAL_TIME = 3'd4;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [5:0]  entry_index;
    logic [63:0] time_value;
    logic        zero_cross_flag;
  } in_t;

  typedef struct packed {
    logic [63:0] next_time;
    logic [5:0]  next_index;
    logic [1:0]  next_kind;
    logic [63:0] sim_time;
    logic        progress_mark;
  } out_t;

  typedef struct packed {
    logic       load_item;
    logic       write_tbl;
    logic       scan_start;
    logic [1:0] scan_sel;
    logic       save_st;
    logic       save_ev;
    logic       save_in;
    logic       pick;
    logic       init_time;
    logic       div_start;
    logic       upd_time;
    logic       upd_el;
    logic       upd_mark;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       scan_done;
    logic       rescan_ev;
    logic       rescan_in;
    logic       div_done;
  } sts_t;

endpackage

[hw/rtl/nems_div100.sv]
// nems_div100: divide by the constant 100 via reciprocal multiply.
// Depends on nems_pkg.
module nems_div100 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);

  // x / 100 = (x >> 2) / 25; quotient estimate from the high half of
  // y * floor(2^64/25) is low by at most one, fixed by one compare
  localparam logic [63:0] QUARTER = 64'(nems_pkg::PROGRESS_PARTS >> 2);

  localparam logic [2:0] PH_LL    = 3'd0;
  localparam logic [2:0] PH_LH    = 3'd1;
  localparam logic [2:0] PH_HL    = 3'd2;
  localparam logic [2:0] PH_HH    = 3'd3;
  localparam logic [2:0] PH_MUL25 = 3'd4;
  localparam logic [2:0] PH_FIX   = 3'd5;

  logic [61:0]  y_q;
  logic [127:0] acc_q, acc_d;
  logic [63:0]  q_q, q_d;
  logic [63:0]  t_q, t_d;
  logic [2:0]   ph_q, ph_d;
  logic         busy_q, busy_d;
  logic [63:0]  y64, q0, rem;
  logic [31:0]  ma, mb;
  logic [63:0]  prod;
  logic [127:0] addend;

  assign y64 = {2'b00, y_q};
  assign q0  = acc_q[127:64];
  assign rem = y64 - t_q;

  always_comb begin
    case (ph_q)
      PH_LL: begin
        ma = y64[31:0];
        mb = nems_pkg::RECIP_25[31:0];
      end
      PH_LH: begin
        ma = y64[31:0];
        mb = nems_pkg::RECIP_25[63:32];
      end
      PH_HL: begin
        ma = y64[63:32];
        mb = nems_pkg::RECIP_25[31:0];
      end
      default: begin
        ma = y64[63:32];
        mb = nems_pkg::RECIP_25[63:32];
      end
    endcase
  end

  assign prod = {32'd0, ma} * {32'd0, mb};

  always_comb begin
    case (ph_q)
      PH_LL:        addend = {64'd0, prod};
      PH_LH, PH_HL: addend = {32'd0, prod, 32'd0};
      default:      addend = {prod, 64'd0};
    endcase
  end

  always_comb begin
    acc_d  = acc_q;
    q_d    = q_q;
    t_d    = t_q;
    ph_d   = ph_q;
    busy_d = busy_q;
    if (start_i) begin
      acc_d  = '0;
      ph_d   = PH_LL;
      busy_d = 1'b1;
    end else if (busy_q) begin
      ph_d = ph_q + 3'd1;
      case (ph_q)
        PH_LL, PH_LH, PH_HL, PH_HH: acc_d = acc_q + addend;
        PH_MUL25: begin
          // 25 * q0 as 16q + 8q + q
          q_d = q0;
          t_d = {q0[59:0], 4'd0} + {q0[60:0], 3'd0} + q0;
        end
        PH_FIX: begin
          if (rem >= QUARTER) q_d = q_q + 64'd1;
          busy_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= PH_LL;
    end else begin
      busy_q <= busy_d;
      ph_q   <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) y_q <= dividend_i[63:2];
    acc_q <= acc_d;
    q_q   <= q_d;
    t_q   <= t_d;
  end

  assign done_o     = !busy_q;
  assign quotient_o = q_q;

endmodule

[hw/rtl/nems_ctrl.sv]
// nems_ctrl: sequencer for writes, table scans, time update and result hand-off.
// Depends on nems_pkg.
module nems_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  nems_pkg::sts_t    sts_i,
  output nems_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_SCAN_ST  = 4'd2;
  localparam logic [3:0] S_SCAN_EV  = 4'd3;
  localparam logic [3:0] S_SCAN_IN  = 4'd4;
  localparam logic [3:0] S_PICK     = 4'd5;
  localparam logic [3:0] S_INIT_T   = 4'd6;
  localparam logic [3:0] S_INIT_DIV = 4'd7;
  localparam logic [3:0] S_UPD_T    = 4'd8;
  localparam logic [3:0] S_UPD_EL   = 4'd9;
  localparam logic [3:0] S_UPD_MARK = 4'd10;
  localparam logic [3:0] S_EMIT     = 4'd11;

  logic [3:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;
  logic       is_init;

  assign is_init = sts_i.op == nems_pkg::OP_INIT;

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q && !out_ready_i;
    cmd_o    = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.op)
          nems_pkg::OP_WR_STATE, nems_pkg::OP_WR_EVENT,
          nems_pkg::OP_WR_INPUT, nems_pkg::OP_WR_FLAG: begin
            cmd_o.write_tbl = 1'b1;
            state_d = S_IDLE;
          end
          nems_pkg::OP_INIT, nems_pkg::OP_UPDATE: begin
            cmd_o.scan_start = 1'b1;
            cmd_o.scan_sel   = nems_pkg::KIND_STATE;
            state_d = S_SCAN_ST;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SCAN_ST: begin
        if (sts_i.scan_done) begin
          cmd_o.save_st = 1'b1;
          if (is_init || sts_i.rescan_ev) begin
            cmd_o.scan_start = 1'b1;
            cmd_o.scan_sel   = nems_pkg::KIND_EVENT;
            state_d = S_SCAN_EV;
          end else if (sts_i.rescan_in) begin
            cmd_o.scan_start = 1'b1;
            cmd_o.scan_sel   = nems_pkg::KIND_INPUT;
            state_d = S_SCAN_IN;
          end else begin
            state_d = S_PICK;
          end
        end
      end
      S_SCAN_EV: begin
        if (sts_i.scan_done) begin
          cmd_o.save_ev = 1'b1;
          if (is_init || sts_i.rescan_in) begin
            cmd_o.scan_start = 1'b1;
            cmd_o.scan_sel   = nems_pkg::KIND_INPUT;
            state_d = S_SCAN_IN;
          end else begin
            state_d = S_PICK;
          end
        end
      end
      S_SCAN_IN: begin
        if (sts_i.scan_done) begin
          cmd_o.save_in = 1'b1;
          state_d = S_PICK;
        end
      end
      S_PICK: begin
        cmd_o.pick = 1'b1;
        state_d = is_init ? S_INIT_T : S_UPD_T;
      end
      S_INIT_T: begin
        cmd_o.init_time = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d = S_INIT_DIV;
      end
      S_INIT_DIV: begin
        if (sts_i.div_done) state_d = S_EMIT;
      end
      S_UPD_T: begin
        cmd_o.upd_time = 1'b1;
        state_d = S_UPD_EL;
      end
      S_UPD_EL: begin
        cmd_o.upd_el = 1'b1;
        state_d = S_UPD_MARK;
      end
      S_UPD_MARK: begin
        cmd_o.upd_mark = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        // output register free or draining this cycle
        if (!ovalid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = ovalid_q;

endmodule

[hw/rtl/nems_dp.sv]
// nems_dp: tables, scan unit, cached minima, time and progress registers, result word.
// Depends on nems_pkg and nems_div100.
module nems_dp #(
  parameter int MAX_STATES = 64,
  parameter int MAX_EVENTS = 64,
  parameter int MAX_INPUTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nems_pkg::in_t      in_data_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i,
  input  nems_pkg::cmd_t     cmd_i,
  output nems_pkg::sts_t     sts_o,
  output nems_pkg::out_t     out_data_o
);

  localparam int MAX_SE = (MAX_STATES > MAX_EVENTS) ? MAX_STATES : MAX_EVENTS;
  localparam int MAX_ALL = (MAX_SE > MAX_INPUTS) ? MAX_SE : MAX_INPUTS;
  localparam int CW  = $clog2(MAX_ALL + 1);
  localparam int AWS = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int AWE = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int AWI = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

  // tables
  logic [63:0] st_mem [MAX_STATES];
  logic [63:0] ev_mem [MAX_EVENTS];
  logic [63:0] in_mem [MAX_INPUTS];
  logic        zc_mem [MAX_STATES];

  // configuration
  logic [6:0]  num_st_q, num_ev_q, num_in_q;
  logic [63:0] start_q, final_q;

  // latched item
  nems_pkg::in_t item_q;

  // scan unit
  logic [1:0]    sel_q;
  logic [CW-1:0] cnt_q, pidx_q, bi_q;
  logic          pend_q;
  logic [63:0]   best_q;
  logic [63:0]   rd_st_q, rd_ev_q, rd_in_q, rd;
  logic [CW-1:0] lim, ns, ne, ni;

  // cached results and step state
  logic [63:0]   st_min_q, cev_min_q, cin_min_q, mv_q, cur_q, step_q, el_q;
  logic [CW-1:0] st_idx_q, cev_idx_q, cin_idx_q, mi_q;
  logic [1:0]    kind_q;
  logic [CW-1:0] last_idx_q;
  logic [1:0]    last_kind_q;
  logic [6:0]    count_q;
  logic [70:0]   thr_q;
  logic          ge_start_q, mark_q, zc_rd_q;
  nems_pkg::out_t out_q;

  logic [31:0] idx32, cnt32, li32, mi32;
  logic [64:0] sum;
  logic [63:0] dvd, quo;
  logic        div_done;

  function automatic logic [CW-1:0] clamp(input logic [6:0] n, input int cap);
    logic [31:0] n32;
    n32 = 32'(n);
    return (n32 > 32'(cap)) ? CW'(cap) : CW'(n32);
  endfunction

  assign ns = clamp(num_st_q, MAX_STATES);
  assign ne = clamp(num_ev_q, MAX_EVENTS);
  assign ni = clamp(num_in_q, MAX_INPUTS);

  assign idx32 = 32'(item_q.entry_index);
  assign cnt32 = 32'(cnt_q);
  assign li32  = 32'(last_idx_q);
  assign mi32  = 32'(mi_q);

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_st_q <= '0;
      num_ev_q <= '0;
      num_in_q <= '0;
      start_q  <= '0;
      final_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nems_pkg::CFG_NUM_STATES: num_st_q <= cfg_data_i[6:0];
        nems_pkg::CFG_NUM_EVENTS: num_ev_q <= cfg_data_i[6:0];
        nems_pkg::CFG_NUM_INPUTS: num_in_q <= cfg_data_i[6:0];
        nems_pkg::CFG_START_TIME: start_q  <= cfg_data_i;
        nems_pkg::CFG_FINAL_TIME: final_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= in_data_i;
  end

  // table writes and registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_tbl) begin
      case (item_q.opcode)
        nems_pkg::OP_WR_STATE:
          if (idx32 < 32'(MAX_STATES)) st_mem[idx32[AWS-1:0]] <= item_q.time_value;
        nems_pkg::OP_WR_EVENT:
          if (idx32 < 32'(MAX_EVENTS)) ev_mem[idx32[AWE-1:0]] <= item_q.time_value;
        nems_pkg::OP_WR_INPUT:
          if (idx32 < 32'(MAX_INPUTS)) in_mem[idx32[AWI-1:0]] <= item_q.time_value;
        nems_pkg::OP_WR_FLAG:
          if (idx32 < 32'(MAX_STATES)) zc_mem[idx32[AWS-1:0]] <= item_q.zero_cross_flag;
        default: ;
      endcase
    end
    rd_st_q <= st_mem[cnt32[AWS-1:0]];
    rd_ev_q <= ev_mem[cnt32[AWE-1:0]];
    rd_in_q <= in_mem[cnt32[AWI-1:0]];
    zc_rd_q <= zc_mem[li32[AWS-1:0]];
  end

  always_comb begin
    case (sel_q)
      nems_pkg::KIND_EVENT: begin
        rd = rd_ev_q;
        lim = ne;
      end
      nems_pkg::KIND_INPUT: begin
        rd = rd_in_q;
        lim = ni;
      end
      default: begin
        rd = rd_st_q;
        lim = ns;
      end
    endcase
  end

  // linear scan: address issued one cycle, compared the next
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q  <= nems_pkg::KIND_STATE;
      cnt_q  <= '0;
      pend_q <= 1'b0;
    end else if (cmd_i.scan_start) begin
      sel_q  <= cmd_i.scan_sel;
      cnt_q  <= '0;
      pend_q <= 1'b0;
    end else if (cnt_q < lim) begin
      cnt_q  <= cnt_q + CW'(1);
      pend_q <= 1'b1;
    end else begin
      pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= cnt_q;
    if (cmd_i.scan_start) begin
      best_q <= nems_pkg::TIME_INF;
      bi_q   <= '0;
    end else if (pend_q && rd < best_q) begin
      best_q <= rd;
      bi_q   <= pidx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.save_st) begin
      st_min_q <= best_q;
      st_idx_q <= bi_q;
    end
  end

  assign sum = {1'b0, cur_q} + {1'b0, mv_q};
  assign dvd = (final_q >= start_q) ? final_q - start_q : '0;

  nems_div100 u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // step state with reset values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cev_min_q   <= nems_pkg::TIME_INF;
      cev_idx_q   <= '0;
      cin_min_q   <= nems_pkg::TIME_INF;
      cin_idx_q   <= '0;
      last_kind_q <= nems_pkg::KIND_STATE;
      last_idx_q  <= '0;
      cur_q       <= '0;
      step_q      <= '0;
      count_q     <= 7'd1;
      thr_q       <= '0;
      mark_q      <= 1'b0;
    end else begin
      if (cmd_i.save_ev) begin
        cev_min_q <= best_q;
        cev_idx_q <= bi_q;
      end
      if (cmd_i.save_in) begin
        cin_min_q <= best_q;
        cin_idx_q <= bi_q;
      end
      if (cmd_i.pick) begin
        if (cin_min_q < st_min_q && cin_min_q < cev_min_q) begin
          last_kind_q <= nems_pkg::KIND_INPUT;
          last_idx_q  <= cin_idx_q;
        end else if (cev_min_q < st_min_q) begin
          last_kind_q <= nems_pkg::KIND_EVENT;
          last_idx_q  <= cev_idx_q;
        end else begin
          last_kind_q <= nems_pkg::KIND_STATE;
          last_idx_q  <= st_idx_q;
        end
      end
      if (cmd_i.init_time) begin
        cur_q   <= sum[64] ? nems_pkg::TIME_INF : sum[63:0];
        count_q <= 7'd1;
        mark_q  <= 1'b0;
      end
      // quotient settles before the result is emitted
      if (cmd_i.div_start) begin
        step_q <= '0;
        thr_q  <= '0;
      end else if (cmd_i.load_out && item_q.opcode == nems_pkg::OP_INIT) begin
        step_q <= quo;
        thr_q  <= 71'(quo);
      end
      if (cmd_i.upd_time) cur_q <= mv_q;
      if (cmd_i.upd_mark) begin
        if (cur_q == nems_pkg::TIME_INF || (ge_start_q && 71'(el_q) >= thr_q)) begin
          mark_q <= 1'b1;
          if (count_q < nems_pkg::COUNT_MAX) begin
            count_q <= count_q + 7'd1;
            thr_q   <= thr_q + 71'(step_q);
          end
        end else begin
          mark_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pick) begin
      if (cin_min_q < st_min_q && cin_min_q < cev_min_q) begin
        mv_q   <= cin_min_q;
        mi_q   <= cin_idx_q;
        kind_q <= nems_pkg::KIND_INPUT;
      end else if (cev_min_q < st_min_q) begin
        mv_q   <= cev_min_q;
        mi_q   <= cev_idx_q;
        kind_q <= nems_pkg::KIND_EVENT;
      end else begin
        mv_q   <= st_min_q;
        mi_q   <= st_idx_q;
        kind_q <= nems_pkg::KIND_STATE;
      end
    end
    if (cmd_i.upd_el) begin
      el_q       <= cur_q - start_q;
      ge_start_q <= cur_q >= start_q;
    end
    if (cmd_i.load_out) begin
      out_q.next_time     <= mv_q;
      out_q.next_index    <= mi32[5:0];
      out_q.next_kind     <= kind_q;
      out_q.sim_time      <= cur_q;
      out_q.progress_mark <= mark_q;
    end
  end

  assign sts_o.op        = item_q.opcode;
  assign sts_o.scan_done = !(cnt_q < lim) && !pend_q;
  assign sts_o.rescan_ev = (last_kind_q == nems_pkg::KIND_STATE && ne != '0 &&
                            li32 < 32'(MAX_STATES) && zc_rd_q) ||
                           last_kind_q == nems_pkg::KIND_EVENT;
  assign sts_o.rescan_in = last_kind_q == nems_pkg::KIND_INPUT;
  assign sts_o.div_done  = div_done;
  assign out_data_o      = out_q;

endmodule

[hw/rtl/next_event_min_selector_top.sv]
// next_event_min_selector_top: linear-scan next-event scheduler, top level.
// Joins nems_ctrl and nems_dp; depends on nems_pkg.
//
// Input channel (valid/ready) carries one word: a table write (state,
// event, input time or zero-crossing flag), an init or an update.
// Writes give no result. Init and update each give one result word on
// the output channel (valid/ready). An update scans the state table
// and, when the last winner calls for it, the event or input table;
// table scans take one entry per cycle. Init scans all three tables and
// then runs the reciprocal divide for the progress step. One word is in
// work at a time. Config writes (cfg_we_i, cfg_idx_i, cfg_data_i) land
// at once; the user must make them only while the block is idle, as
// the block itself does not enforce it.
// Reset clears counts, cached event and input minima, time and progress
// state; table contents are undefined until written. A stalled receiver
// holds the result in the output register; the next input word is
// accepted meanwhile, and its result waits until that register drains.
module next_event_min_selector_top #(
  parameter int MAX_STATES = 64,
  parameter int MAX_EVENTS = 64,
  parameter int MAX_INPUTS = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  nems_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output nems_pkg::out_t  out_data_o,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [63:0]     cfg_data_i
);

  nems_pkg::cmd_t cmd;
  nems_pkg::sts_t sts;

  nems_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  nems_dp #(
    .MAX_STATES (MAX_STATES),
    .MAX_EVENTS (MAX_EVENTS),
    .MAX_INPUTS (MAX_INPUTS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

[tb/sv/tb_next_event_min_selector_top.sv]
// Self-checking testbench for next_event_min_selector_top: queued stimulus,
// bursty driver, stalling receiver, monitor, in-bench predictor of the scheduler.
// Depends on nems_pkg and the RTL under hw/rtl.
module tb_next_event_min_selector_top;

  localparam int TBL = 64;
  localparam int LIMIT = 3000000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  nems_pkg::in_t   in_data_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  nems_pkg::out_t  out_data_o;
  logic            cfg_we_i = 1'b0;
  logic [2:0]      cfg_idx_i = '0;
  logic [63:0]     cfg_data_i = '0;

  next_event_min_selector_top DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [63:0] st_tbl [TBL];
  logic [63:0] ev_tbl [TBL];
  logic [63:0] in_tbl [TBL];
  logic        zc_tbl [TBL];
  logic [63:0] ev_min, in_min, now_t, step_sz, t0, t1;
  logic [5:0]  ev_idx, in_idx, prev_idx;
  logic [1:0]  prev_kind;
  logic [6:0]  mark_cnt;
  int          n_st, n_ev, n_in;
  bit          st_ok [TBL];

  nems_pkg::in_t   pending_words[$];
  nems_pkg::out_t  expected_words[$];
  int    errors = 0;
  int    issued = 0;
  bit    hold_rx = 0;

  task automatic find_min(input int which, input int n, output logic [63:0] mv,
                          output logic [5:0] mi);
    logic [63:0] v;
    mv = nems_pkg::TIME_INF;
    mi = '0;
    for (int j = 0; j < n; j++) begin
      v = (which == 0) ? st_tbl[j] : (which == 1) ? ev_tbl[j] : in_tbl[j];
      if (v < mv) begin
        mv = v;
        mi = j[5:0];
      end
    end
  endtask

  task automatic schedule_step(input nems_pkg::in_t w);
    logic [63:0] mv;
    logic [5:0]  mi;
    logic [1:0]  kd;
    logic        mk;
    nems_pkg::out_t r;
    mk = 1'b0;
    case (w.opcode)
      nems_pkg::OP_WR_STATE: st_tbl[w.entry_index] = w.time_value;
      nems_pkg::OP_WR_EVENT: ev_tbl[w.entry_index] = w.time_value;
      nems_pkg::OP_WR_INPUT: in_tbl[w.entry_index] = w.time_value;
      nems_pkg::OP_WR_FLAG:  zc_tbl[w.entry_index] = w.zero_cross_flag;
      nems_pkg::OP_INIT, nems_pkg::OP_UPDATE: begin
        find_min(0, n_st, mv, mi);
        kd = nems_pkg::KIND_STATE;
        if (w.opcode == nems_pkg::OP_INIT) begin
          find_min(1, n_ev, ev_min, ev_idx);
          find_min(2, n_in, in_min, in_idx);
        end else begin
          if ((prev_kind == nems_pkg::KIND_STATE && n_ev != 0 && zc_tbl[prev_idx]) ||
              prev_kind == nems_pkg::KIND_EVENT)
            find_min(1, n_ev, ev_min, ev_idx);
          if (prev_kind == nems_pkg::KIND_INPUT) find_min(2, n_in, in_min, in_idx);
        end
        if (ev_min < mv) begin mv = ev_min; mi = ev_idx; kd = nems_pkg::KIND_EVENT; end
        if (in_min < mv) begin mv = in_min; mi = in_idx; kd = nems_pkg::KIND_INPUT; end
        prev_kind = kd;
        prev_idx = mi;
        if (w.opcode == nems_pkg::OP_INIT) begin
          if (mv == nems_pkg::TIME_INF || now_t > nems_pkg::TIME_INF - mv)
            now_t = nems_pkg::TIME_INF;
          else now_t = now_t + mv;
          step_sz = (t1 >= t0) ? (t1 - t0) / 100 : 64'd0;
          mark_cnt = 7'd1;
        end else begin
          now_t = mv;
          if (now_t == nems_pkg::TIME_INF) mk = 1'b1;
          else if (now_t >= t0) begin
            if (step_sz == 0) mk = 1'b1;
            else mk = ((now_t - t0) / step_sz) >= 64'(mark_cnt);
          end
          if (mk && mark_cnt < nems_pkg::COUNT_MAX) mark_cnt++;
        end
        r.next_time = mv;
        r.next_index = mi;
        r.next_kind = kd;
        r.sim_time = now_t;
        r.progress_mark = mk;
        expected_words.push_back(r);
      end
      default: ;
    endcase
  endtask

  // driver: bursts of random length, random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        schedule_step(in_data_i);
        issued++;
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_words.pop_front();
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 20);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern; one long hold-off counted here
  int pat = 0;
  int hold_cnt = 0;
  bit hold_done = 0;
  always @(posedge clk_i) begin
    pat <= pat + 1;
    if (hold_rx && !hold_done) begin
      out_ready_i <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == 2000) hold_done <= 1'b1;
    end
    else if (pat[9]) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(0, 3) != 0);
  end

  // monitor
  always @(posedge clk_i) begin
    nems_pkg::out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (out_data_o.next_time !== e.next_time) begin
          $error("next_time exp %h got %h", e.next_time, out_data_o.next_time); errors++;
        end
        if (out_data_o.next_index !== e.next_index) begin
          $error("next_index exp %0d got %0d", e.next_index, out_data_o.next_index);
          errors++;
        end
        if (out_data_o.next_kind !== e.next_kind) begin
          $error("next_kind exp %0d got %0d", e.next_kind, out_data_o.next_kind); errors++;
        end
        if (out_data_o.sim_time !== e.sim_time) begin
          $error("sim_time exp %h got %h", e.sim_time, out_data_o.sim_time); errors++;
        end
        if (out_data_o.progress_mark !== e.progress_mark) begin
          $error("progress_mark exp %0d got %0d", e.progress_mark,
                 out_data_o.progress_mark);
          errors++;
        end
      end
    end
  end

  // timeout
  int cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_next_event_min_selector_top: done, errors");
      $finish;
    end
  end

  function automatic logic [63:0] rnd_time();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = nems_pkg::TIME_INF;
      1: v = 64'd0;
      2: v = {32'd0, $urandom};
      3: v = {24'd0, 8'($urandom_range(0, 255)), $urandom};
      4: v = 64'(1000 + $urandom_range(0, 40)); // many ties
      default: ;
    endcase
    return v;
  endfunction

  function automatic nems_pkg::in_t mk_word(logic [2:0] op, int idx, logic [63:0] tv,
                                            bit f);
    nems_pkg::in_t w;
    w.opcode = op;
    w.entry_index = idx[5:0];
    w.time_value = tv;
    w.zero_cross_flag = f;
    return w;
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      nems_pkg::CFG_NUM_STATES: n_st = (val[6:0] > TBL) ? TBL : val[6:0];
      nems_pkg::CFG_NUM_EVENTS: n_ev = (val[6:0] > TBL) ? TBL : val[6:0];
      nems_pkg::CFG_NUM_INPUTS: n_in = (val[6:0] > TBL) ? TBL : val[6:0];
      nems_pkg::CFG_START_TIME: t0 = val;
      nems_pkg::CFG_FINAL_TIME: t1 = val;
      default: ;
    endcase
  endtask

  // wait for every queued word to be taken and every result drained
  task automatic drain();
    int target;
    target = issued + pending_words.size();
    while (issued < target || in_valid_i || expected_words.size() != 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  // fill all entries in use so scans never read an unwritten entry
  task automatic fill_tables(int ns, int ne, int ni);
    for (int j = 0; j < ns; j++) begin
      if (!st_ok[j] || $urandom_range(0, 1)) begin
        pending_words.push_back(mk_word(nems_pkg::OP_WR_STATE, j, rnd_time(), 0));
        st_ok[j] = 1;
      end
      pending_words.push_back(mk_word(nems_pkg::OP_WR_FLAG, j, rnd_time(),
                                      1'($urandom_range(0, 1))));
    end
    for (int j = 0; j < ne; j++)
      pending_words.push_back(mk_word(nems_pkg::OP_WR_EVENT, j, rnd_time(), 0));
    for (int j = 0; j < ni; j++)
      pending_words.push_back(mk_word(nems_pkg::OP_WR_INPUT, j, rnd_time(), 0));
  endtask

  initial begin
    int ns, ne, ni, nphase, kind;
    logic [63:0] s, f;
    prev_kind = nems_pkg::KIND_STATE; prev_idx = '0;
    ev_min = nems_pkg::TIME_INF; in_min = nems_pkg::TIME_INF;
    ev_idx = '0; in_idx = '0; now_t = '0; step_sz = '0; mark_cnt = 7'd1;
    n_st = 0; n_ev = 0; n_in = 0; t0 = '0; t1 = '0;
    for (int j = 0; j < TBL; j++) zc_tbl[j] = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty tables, update before init, unused opcodes
    pending_words.push_back(mk_word(nems_pkg::OP_UPDATE, 0, 0, 0));
    pending_words.push_back(mk_word(3'd6, 5, nems_pkg::TIME_INF, 1));
    pending_words.push_back(mk_word(3'd7, 63, 0, 0));
    pending_words.push_back(mk_word(nems_pkg::OP_INIT, 0, 0, 0));
    drain();
    cfg_write(nems_pkg::CFG_NUM_STATES, 64'd2);
    cfg_write(nems_pkg::CFG_NUM_EVENTS, 64'd2);
    cfg_write(nems_pkg::CFG_NUM_INPUTS, 64'd2);
    cfg_write(nems_pkg::CFG_START_TIME, 64'd0);
    cfg_write(nems_pkg::CFG_FINAL_TIME, 64'd1000);
    // ties: equal times everywhere, state wins; then event, then input
    for (int j = 0; j < 2; j++) begin
      pending_words.push_back(mk_word(nems_pkg::OP_WR_STATE, j, 64'd50, 0));
      pending_words.push_back(mk_word(nems_pkg::OP_WR_EVENT, j, 64'd50, 0));
      pending_words.push_back(mk_word(nems_pkg::OP_WR_INPUT, j, 64'd50, 0));
      pending_words.push_back(mk_word(nems_pkg::OP_WR_FLAG, j, 0, 1));
      st_ok[j] = 1;
    end
    pending_words.push_back(mk_word(nems_pkg::OP_INIT, 0, 0, 0));
    pending_words.push_back(mk_word(nems_pkg::OP_WR_STATE, 0, nems_pkg::TIME_INF, 0));
    pending_words.push_back(mk_word(nems_pkg::OP_WR_STATE, 1, nems_pkg::TIME_INF, 0));
    pending_words.push_back(mk_word(nems_pkg::OP_UPDATE, 0, 0, 0));
    pending_words.push_back(mk_word(nems_pkg::OP_WR_EVENT, 0, nems_pkg::TIME_INF, 0));
    pending_words.push_back(mk_word(nems_pkg::OP_WR_EVENT, 1, nems_pkg::TIME_INF, 0));
    pending_words.push_back(mk_word(nems_pkg::OP_UPDATE, 0, 0, 0));
    pending_words.push_back(mk_word(nems_pkg::OP_WR_INPUT, 0, nems_pkg::TIME_INF, 0));
    pending_words.push_back(mk_word(nems_pkg::OP_WR_INPUT, 1, nems_pkg::TIME_INF, 0));
    pending_words.push_back(mk_word(nems_pkg::OP_UPDATE, 0, 0, 0));  // all infinite
    pending_words.push_back(mk_word(nems_pkg::OP_INIT, 0, 0, 0));    // init overflow to inf
    drain();

    // random phases with changing config; counts above 64 saturate
    nphase = 0;
    while (issued < 1900) begin
      kind = $urandom_range(0, 9);
      ns = (kind == 0) ? 0 : (kind == 1) ? 64 : $urandom_range(1, 8);
      ne = (kind == 2) ? 0 : (kind == 1) ? 64 : $urandom_range(0, 8);
      ni = (kind == 3) ? 0 : (kind == 1) ? 64 : $urandom_range(0, 8);
      cfg_write(nems_pkg::CFG_NUM_STATES, (kind == 1 && nphase[0]) ? 64'd127 : 64'(ns));
      cfg_write(nems_pkg::CFG_NUM_EVENTS, (kind == 1 && nphase[0]) ? 64'd100 : 64'(ne));
      cfg_write(nems_pkg::CFG_NUM_INPUTS, 64'(ni));
      s = (kind == 4) ? 64'd0 : (kind == 5) ? nems_pkg::TIME_INF : {8'd0, $urandom, 24'd0};
      f = (kind == 4) ? nems_pkg::TIME_INF : (kind == 6) ? 64'd0 :
          s + {16'd0, $urandom, 16'd0};
      cfg_write(nems_pkg::CFG_START_TIME, s);
      cfg_write(nems_pkg::CFG_FINAL_TIME, f);
      // fill the tables in use, then init before the random updates
      fill_tables(ns, ne, ni);
      pending_words.push_back(mk_word(nems_pkg::OP_INIT, 0, 0, 0));
      repeat ($urandom_range(10, 30)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: pending_words.push_back(mk_word(nems_pkg::OP_UPDATE,
                          $urandom_range(0, 63), {$urandom, $urandom}, 1'($urandom)));
          4: if (ns > 0) pending_words.push_back(mk_word(nems_pkg::OP_WR_STATE,
                   $urandom_range(0, ns - 1), s + {32'd0, $urandom}, 0));
          5: if (ne > 0) pending_words.push_back(mk_word(nems_pkg::OP_WR_EVENT,
                   $urandom_range(0, ne - 1), rnd_time(), 0));
          6: if (ni > 0) pending_words.push_back(mk_word(nems_pkg::OP_WR_INPUT,
                   $urandom_range(0, ni - 1), rnd_time(), 0));
          7: pending_words.push_back(mk_word(nems_pkg::OP_WR_FLAG, $urandom_range(0, 63),
                                             {$urandom, $urandom}, 1'($urandom)));
          // random table writes at any index; those beyond the counts are never scanned
          8: pending_words.push_back(mk_word(3'($urandom_range(0, 2)),
                                             $urandom_range(0, 63), rnd_time(),
                                             1'($urandom)));
          default: pending_words.push_back(mk_word(3'($urandom_range(6, 7)),
                                           $urandom_range(0, 63), rnd_time(),
                                           1'($urandom)));
        endcase
      end
      if (nphase == 3) begin
        // long receiver hold-off while the sender keeps offering
        hold_rx = 1;
        wait (hold_done);
        hold_rx = 0;
      end
      drain();
      nphase++;
    end
    repeat (300) @(posedge clk_i);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("tb_next_event_min_selector_top: done, clean");
    end else begin
      $display("tb_next_event_min_selector_top: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/nems_pkg.sv
hw/rtl/nems_div100.sv
hw/rtl/nems_ctrl.sv
hw/rtl/nems_dp.sv
hw/rtl/next_event_min_selector_top.sv
tb/sv/tb_next_event_min_selector_top.sv
